### hdl/rcmc_pkg.sv
// Package for the relative change max check block.
// Holds the controller states, controller-to-datapath commands and register map constants.
// No dependencies.
package rcmc_pkg;

  localparam int unsigned TOL_WIDTH = 31;
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;

  // register index taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mag;
    logic prep;
    logic step;
    logic finish;
  } cmd_t;

endpackage

### hdl/rcmc_if.sv
// Valid/ready channel interfaces for the relative change max check block.
// Input item channel and result item channel; no dependencies.
interface rcmc_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] new_flux;
  logic signed [VALUE_WIDTH-1:0] old_flux;
  logic                          group_active;
  logic                          last_cell;

  modport source (output valid, new_flux, old_flux, group_active, last_cell, input ready);
  modport sink (input valid, new_flux, old_flux, group_active, last_cell, output ready);
endinterface

interface rcmc_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic        [VALUE_WIDTH-1:0] cell_change;
  logic                          skipped;
  logic                          near_zero_old;
  logic signed [VALUE_WIDTH-1:0] adjusted_old;
  logic        [VALUE_WIDTH-1:0] running_max;
  logic                          max_valid;
  logic                          final_res;

  modport source (output valid, cell_change, skipped, near_zero_old, adjusted_old,
                  running_max, max_valid, final_res, input ready);
  modport sink (input valid, cell_change, skipped, near_zero_old, adjusted_old,
                running_max, max_valid, final_res, output ready);
endinterface

### hdl/relative_change_max_check_unit.sv
// Accepted items pass through magnitude, divider setup, divide steps and done states.
// A new item is taken only after the last result is written; one quotient bit per cycle.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_ni low, async): controller idle, result invalid, running maximum cleared,
// tolerance back to 1.
// Top level: APB tolerance register, controller and datapath; uses rcmc_pkg and rcmc_if.
module relative_change_max_check_unit #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  rcmc_in_if.sink                                 in_i,
  rcmc_out_if.source                              out_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [rcmc_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [rcmc_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [rcmc_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                    pready
);

  logic [rcmc_pkg::TOL_WIDTH-1:0] tol_q;
  logic                           reg_hit;
  rcmc_pkg::cmd_t                 cmd;

  assign reg_hit = paddr[2] == rcmc_pkg::REG_TOLERANCE;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? rcmc_pkg::APB_DATA_WIDTH'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= rcmc_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      tol_q <= pwdata[rcmc_pkg::TOL_WIDTH-1:0];
    end
  end

  rcmc_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  rcmc_dp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tolerance_i    (tol_q),
    .new_flux_i     (in_i.new_flux),
    .old_flux_i     (in_i.old_flux),
    .group_active_i (in_i.group_active),
    .last_cell_i    (in_i.last_cell),
    .cell_change_o  (out_o.cell_change),
    .skipped_o      (out_o.skipped),
    .near_zero_old_o(out_o.near_zero_old),
    .adjusted_old_o (out_o.adjusted_old),
    .running_max_o  (out_o.running_max),
    .max_valid_o    (out_o.max_valid),
    .final_res_o    (out_o.final_res)
  );

endmodule

### hdl/rcmc_ctrl.sv
// Controller for the relative change max check block.
// Sequences load, magnitude, divider setup, divide steps and result write; uses rcmc_pkg.
module rcmc_ctrl #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rcmc_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_WIDTH = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

  rcmc_pkg::state_e state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcmc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      rcmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rcmc_pkg::ST_MAG;
        end
      end
      rcmc_pkg::ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = rcmc_pkg::ST_PREP;
      end
      rcmc_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = rcmc_pkg::ST_DIV;
      end
      rcmc_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = rcmc_pkg::ST_DONE;
        end
      end
      rcmc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = rcmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcmc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/rcmc_dp.sv
// Datapath for the relative change max check block.
// Operand registers, restoring divider, running maximum and result register; uses rcmc_pkg.
module rcmc_dp #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcmc_pkg::cmd_t                      cmd_i,
  input  logic [rcmc_pkg::TOL_WIDTH-1:0]      tolerance_i,
  input  logic signed [VALUE_WIDTH-1:0]       new_flux_i,
  input  logic signed [VALUE_WIDTH-1:0]       old_flux_i,
  input  logic                                group_active_i,
  input  logic                                last_cell_i,
  output logic        [VALUE_WIDTH-1:0]       cell_change_o,
  output logic                                skipped_o,
  output logic                                near_zero_old_o,
  output logic signed [VALUE_WIDTH-1:0]       adjusted_old_o,
  output logic        [VALUE_WIDTH-1:0]       running_max_o,
  output logic                                max_valid_o,
  output logic                                final_res_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned DW = VW + 1 + FB;
  localparam int unsigned XW = (DW > 2 * VW) ? DW : 2 * VW;
  localparam int unsigned TW = (VW > rcmc_pkg::TOL_WIDTH) ? VW : rcmc_pkg::TOL_WIDTH;
  localparam logic [VW-1:0] ONE_FIX = (FB < VW) ? (VW'(1) << FB) : '0;

  logic signed [VW-1:0] new_q, old_q;
  logic                 active_q, last_q;
  logic [VW:0]          num_q;
  logic [VW-1:0]        den_q, nmag_q;
  logic                 near_q, sat_q;
  logic [VW-1:0]        rem_q, lo_q, quo_q;
  logic [VW-1:0]        max_q;
  logic                 seen_q;

  logic signed [VW:0]   diff;
  logic [VW:0]          num_c;
  logic [VW-1:0]        omag_c, nmag_c;
  logic                 near_c;
  logic [DW-1:0]        dvd_c;
  logic [VW:0]          rem_sh;
  logic                 ge;
  logic [VW-1:0]        change_c, max_new;
  logic                 seen_new;

  always_comb begin
    diff    = {new_q[VW-1], new_q} - {old_q[VW-1], old_q};
    num_c   = diff[VW] ? (~diff + 1'b1) : diff;
    omag_c  = old_q[VW-1] ? (~old_q + 1'b1) : old_q;
    nmag_c  = new_q[VW-1] ? (~new_q + 1'b1) : new_q;
    near_c  = active_q && (TW'(omag_c) < TW'(tolerance_i));
    dvd_c   = {num_q, {FB{1'b0}}};
    rem_sh  = {rem_q, lo_q[VW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    if (!active_q) begin
      change_c = '0;
    end else if (near_q) begin
      change_c = nmag_q;
    end else if (sat_q) begin
      change_c = '1;
    end else begin
      change_c = quo_q;
    end
    max_new  = (active_q && (!seen_q || change_c > max_q)) ? change_c : max_q;
    seen_new = seen_q || active_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_q    <= new_flux_i;
      old_q    <= old_flux_i;
      active_q <= group_active_i;
      last_q   <= last_cell_i;
    end
    if (cmd_i.mag) begin
      num_q  <= num_c;
      den_q  <= omag_c;
      nmag_q <= nmag_c;
      near_q <= near_c;
    end
    if (cmd_i.prep) begin
      // quotient fits in VW bits unless the dividend reaches den << VW
      sat_q <= XW'(dvd_c) >= XW'({den_q, {VW{1'b0}}});
      rem_q <= VW'(dvd_c >> VW);
      lo_q  <= dvd_c[VW-1:0];
      quo_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= ge ? VW'(rem_sh - {1'b0, den_q}) : rem_sh[VW-1:0];
      lo_q  <= lo_q << 1;
      quo_q <= {quo_q[VW-2:0], ge};
    end
    if (cmd_i.finish) begin
      cell_change_o   <= change_c;
      skipped_o       <= !active_q;
      near_zero_old_o <= near_q;
      adjusted_old_o  <= near_q ? $signed(ONE_FIX) : old_q;
      running_max_o   <= max_new;
      max_valid_o     <= seen_new;
      final_res_o     <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.finish) begin
      max_q  <= last_q ? '0 : max_new;
      seen_q <= last_q ? 1'b0 : seen_new;
    end
  end

endmodule
